@@ rtl/hbmt_pkg.sv @@
package hbmt_pkg;

  typedef enum logic [1:0] {
    FUNC_MERGE = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_LIST  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_REFRESHED = 3'd1,
    KIND_UNCHANGED = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_REMOVED   = 3'd4,
    KIND_LIVE      = 3'd5,
    KIND_NONE      = 3'd6
  } kind_t;

  localparam logic [1:0] REG_SELF_IDENT = 2'd0;
  localparam logic [1:0] REG_SELF_PORT  = 2'd1;
  localparam logic [1:0] REG_FAIL_TO    = 2'd2;
  localparam logic [1:0] REG_REMOVE_TO  = 2'd3;

  // most results one item may produce
  localparam int MAX_RESULTS = 32;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] member_ident;
    logic [15:0] member_port_in;
    logic [31:0] beat_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] out_ident;
    logic [15:0] out_port;
    logic [31:0] out_beat;
    logic [31:0] out_stamp;
    logic        final_item;
  } out_item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [31:0] self_ident;
    logic [15:0] self_port;
    logic [15:0] fail_to;
    logic [15:0] remove_to;
  } cfg_t;

endpackage

@@ rtl/hbmt_front.sv @@
module hbmt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  hbmt_pkg::in_item_t in_item,
  output logic              q_valid,
  output hbmt_pkg::in_item_t q_item,
  input  logic              q_pop
);

  // two-entry queue; func 3 items are dropped here
  hbmt_pkg::in_item_t mem_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy && (in_item.func != hbmt_pkg::FUNC_NOP);
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop && q_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= !wp_r;
      if (q_pop && q_valid) rp_r <= !rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_item;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_full_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2) |-> busy) else $error("full queue not busy");
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_valid && !push) |=> (cnt_r == $past(cnt_r) - 2'd1))
    else $error("pop not counted");

endmodule

@@ rtl/hbmt_back.sv @@
module hbmt_back #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hbmt_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  hbmt_pkg::in_item_t q_item,
  output logic               q_pop,
  output logic               idle,
  output logic               out_valid,
  output hbmt_pkg::out_item_t out_item
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MERGE = 5'b00010,
    ST_SELF  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_LAST  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [TABLE_ENTRIES-1:0] vld_r;
  logic [31:0] id_r    [TABLE_ENTRIES];
  logic [15:0] port_r  [TABLE_ENTRIES];
  logic [31:0] beat_r  [TABLE_ENTRIES];
  logic [31:0] stamp_r [TABLE_ENTRIES];
  logic [31:0] now_r;
  hbmt_pkg::in_item_t cur_r;
  logic [IW-1:0] idx_r;
  logic [CW-1:0] nout_r;

  // parallel match compares
  logic [TABLE_ENTRIES-1:0] hit, self_hit;
  always_comb begin
    for (int s = 0; s < TABLE_ENTRIES; s++) begin
      hit[s] = vld_r[s] && id_r[s] == cur_r.member_ident &&
               port_r[s] == cur_r.member_port_in;
      self_hit[s] = vld_r[s] && id_r[s] == cfg.self_ident &&
                    port_r[s] == cfg.self_port;
    end
  end

  // lowest hit and lowest free (priority encoders)
  logic [IW-1:0] hit_idx, free_idx;
  logic          any_hit, any_free;
  always_comb begin
    hit_idx = '0; free_idx = '0; any_hit = 1'b0; any_free = 1'b0;
    for (int s = TABLE_ENTRIES - 1; s >= 0; s--) begin
      if (hit[s])    begin hit_idx  = IW'(s); any_hit  = 1'b1; end
      if (!vld_r[s]) begin free_idx = IW'(s); any_free = 1'b1; end
    end
  end

  logic [31:0] age;
  logic        sel;
  logic        scan_end;
  always_comb begin
    age = now_r - stamp_r[idx_r];
    if (cur_r.func == hbmt_pkg::FUNC_TICK) sel = vld_r[idx_r] && age > {16'd0, cfg.remove_to};
    else                                   sel = vld_r[idx_r] && age <= {16'd0, cfg.fail_to};
    // result cap: later slots are skipped (and stay valid on a tick)
    if (32'(nout_r) >= hbmt_pkg::MAX_RESULTS) sel = 1'b0;
    scan_end = (32'(idx_r) == 32'(TABLE_ENTRIES - 1));
  end

  assign idle  = (state_r == ST_IDLE);
  assign q_pop = idle && q_valid;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (q_valid) state_nxt = (q_item.func == hbmt_pkg::FUNC_MERGE) ? ST_MERGE :
                                         (q_item.func == hbmt_pkg::FUNC_TICK) ? ST_SELF : ST_SCAN;
      ST_MERGE: state_nxt = ST_IDLE;
      ST_SELF:  state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_end) state_nxt = (sel || nout_r != '0) ? ST_IDLE : ST_LAST;
      ST_LAST:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vld_r     <= '0;
      now_r     <= '0;
      out_valid <= 1'b0;
      idx_r     <= '0;
      nout_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= (state_r == ST_MERGE) || (state_r == ST_LAST) ||
                   ((state_r == ST_SCAN) && sel);
      unique case (state_r)
        ST_IDLE: begin
          idx_r  <= '0;
          nout_r <= '0;
          if (q_valid && q_item.func == hbmt_pkg::FUNC_TICK) now_r <= now_r + 32'd1;
        end
        ST_MERGE: begin
          if (!any_hit && any_free) vld_r[free_idx] <= 1'b1;
        end
        ST_SCAN: begin
          idx_r <= idx_r + IW'(1);
          if (sel) begin
            nout_r <= nout_r + CW'(1);
            if (cur_r.func == hbmt_pkg::FUNC_TICK) vld_r[idx_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // table payload and result data
  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_item;
    unique case (state_r)
      ST_MERGE: begin
        out_item.final_item <= 1'b1;
        if (any_hit) begin
          out_item.out_ident <= id_r[hit_idx];
          out_item.out_port  <= port_r[hit_idx];
          if (beat_r[hit_idx] < cur_r.beat_in) begin
            beat_r[hit_idx]  <= cur_r.beat_in;
            stamp_r[hit_idx] <= now_r;
            out_item.result_kind <= hbmt_pkg::KIND_REFRESHED;
            out_item.out_beat    <= cur_r.beat_in;
            out_item.out_stamp   <= now_r;
          end else begin
            out_item.result_kind <= hbmt_pkg::KIND_UNCHANGED;
            out_item.out_beat    <= beat_r[hit_idx];
            out_item.out_stamp   <= stamp_r[hit_idx];
          end
        end else begin
          out_item.result_kind <= any_free ? hbmt_pkg::KIND_ADDED : hbmt_pkg::KIND_FULL;
          out_item.out_ident   <= cur_r.member_ident;
          out_item.out_port    <= cur_r.member_port_in;
          out_item.out_beat    <= cur_r.beat_in;
          out_item.out_stamp   <= now_r;
          if (any_free) begin
            id_r[free_idx]    <= cur_r.member_ident;
            port_r[free_idx]  <= cur_r.member_port_in;
            beat_r[free_idx]  <= cur_r.beat_in;
            stamp_r[free_idx] <= now_r;
          end
        end
      end
      ST_SELF: begin
        for (int s = 0; s < TABLE_ENTRIES; s++) begin
          if (self_hit[s]) begin
            beat_r[s]  <= beat_r[s] + 32'd1;
            stamp_r[s] <= now_r;
          end
        end
      end
      ST_SCAN: begin
        out_item.result_kind <= (cur_r.func == hbmt_pkg::FUNC_TICK) ?
                                hbmt_pkg::KIND_REMOVED : hbmt_pkg::KIND_LIVE;
        out_item.out_ident   <= id_r[idx_r];
        out_item.out_port    <= port_r[idx_r];
        out_item.out_beat    <= beat_r[idx_r];
        out_item.out_stamp   <= stamp_r[idx_r];
        // set on the result from the table's last slot only; the top level marks the true last result
        out_item.final_item  <= scan_end;
      end
      ST_LAST: begin
        out_item.result_kind <= hbmt_pkg::KIND_NONE;
        out_item.out_ident   <= '0;
        out_item.out_port    <= '0;
        out_item.out_beat    <= '0;
        out_item.out_stamp   <= now_r;
        out_item.final_item  <= 1'b1;
      end
      default: ;
    endcase
  end

  a_merge_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MERGE) |=> out_valid) else $error("merge gave no result");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && $past(state_r) == ST_IDLE) |-> !out_valid)
    else $error("result while idle");
  a_nout_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nout_r) <= TABLE_ENTRIES) else $error("result count overflow");

endmodule

@@ rtl/hbmt_regs.sv @@
module hbmt_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output hbmt_pkg::cfg_t cfg
);

  hbmt_pkg::cfg_t cfg_r;
  logic [1:0] ri;
  assign ri     = paddr[3:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.self_ident <= '0;
      cfg_r.self_port  <= '0;
      cfg_r.fail_to    <= 16'd5;
      cfg_r.remove_to  <= 16'd20;
    end else if (psel && penable && pwrite) begin
      unique case (ri)
        hbmt_pkg::REG_SELF_IDENT: cfg_r.self_ident <= pwdata;
        hbmt_pkg::REG_SELF_PORT:  cfg_r.self_port  <= pwdata[15:0];
        hbmt_pkg::REG_FAIL_TO:    cfg_r.fail_to    <= pwdata[15:0];
        hbmt_pkg::REG_REMOVE_TO:  cfg_r.remove_to  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ri)
      hbmt_pkg::REG_SELF_IDENT: prdata = cfg_r.self_ident;
      hbmt_pkg::REG_SELF_PORT:  prdata = {16'd0, cfg_r.self_port};
      hbmt_pkg::REG_FAIL_TO:    prdata = {16'd0, cfg_r.fail_to};
      hbmt_pkg::REG_REMOVE_TO:  prdata = {16'd0, cfg_r.remove_to};
      default:                  prdata = '0;
    endcase
  end

endmodule

@@ rtl/heartbeat_membership_table_unit.sv @@
// channel | ports                          | handshake
// input   | start, busy, in_item           | taken when start && !busy
// result  | out_valid, out_item            | no stall
// config  | cfg_psel..cfg_pready           | APB write on psel&penable&pwrite
//
// Merge: from the queue the item is classified, matched/updated, then its result goes out.
// Tick: a self-refresh step, then a scan of one slot a cycle.
// List: a scan of one slot a cycle, plus a none result if none found.
// The scan over the table's single read path sets the rate of tick and list.
// A two-item queue splits intake from execution; busy rises when it is full.
// Reset clears the table's valid bits and time at once; no clearing pass.
module heartbeat_membership_table_unit #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  hbmt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output hbmt_pkg::out_item_t out_item,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [3:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  hbmt_pkg::cfg_t     cfg;
  hbmt_pkg::in_item_t q_item;
  logic q_valid, q_pop, idle;
  hbmt_pkg::out_item_t raw;
  logic raw_valid;

  hbmt_regs u_regs (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata),
    .pready(cfg_pready), .cfg(cfg)
  );

  hbmt_front u_front (
    .clk, .rst_n, .start, .busy, .in_item, .q_valid, .q_item, .q_pop
  );

  hbmt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk, .rst_n, .cfg, .q_valid, .q_item, .q_pop, .idle,
    .out_valid(raw_valid), .out_item(raw)
  );

  // hold one scan result back so final_item can be set on the true last one
  hbmt_pkg::out_item_t hold_r;
  hbmt_pkg::out_item_t hold_out;
  logic hold_v_r;
  logic flush;
  logic drain;
  assign flush = raw_valid && raw.final_item;
  // held item goes out once the scan is over, or right after a flush behind it
  assign drain = hold_v_r && (idle || hold_r.final_item);

  always_comb begin
    hold_out = hold_r;
    hold_out.final_item = !raw_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= raw_valid ? (hold_v_r || flush) : drain;
      if (raw_valid) begin
        hold_v_r <= hold_v_r || !flush;
      end else if (drain) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid) begin
      if (hold_v_r) begin
        out_item <= hold_out;
      end else if (flush) begin
        out_item <= raw;
      end
      hold_r <= raw;
    end else if (drain) begin
      out_item <= hold_out;
    end
  end

endmodule

@@ bench/tb_heartbeat_membership_table_unit.sv @@
`timescale 1ns / 100ps

module tb_heartbeat_membership_table_unit;

  localparam int ENTRIES = 32;
  localparam int MAX_OUT = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3 * ENTRIES + 20;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  hbmt_pkg::in_item_t in_item;
  logic out_valid;
  hbmt_pkg::out_item_t out_item;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [3:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  heartbeat_membership_table_unit #(.TABLE_ENTRIES(ENTRIES)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // shadow of the membership table
  logic        tbl_valid [ENTRIES];
  logic [31:0] tbl_ident [ENTRIES];
  logic [15:0] tbl_port  [ENTRIES];
  logic [31:0] tbl_beat  [ENTRIES];
  logic [31:0] tbl_stamp [ENTRIES];
  logic [31:0] local_time;
  logic [31:0] own_ident;
  logic [15:0] own_port;
  logic [15:0] live_limit;
  logic [15:0] purge_limit;

  hbmt_pkg::out_item_t pending_results[$];
  int mismatch_count;
  int items_sent;
  int results_seen;
  int idle_pct;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH @%0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic hbmt_pkg::out_item_t make_result(hbmt_pkg::kind_t kind,
                                                      logic [31:0] id,
                                                      logic [15:0] port,
                                                      logic [31:0] beat,
                                                      logic [31:0] stamp);
    hbmt_pkg::out_item_t r;
    r.result_kind = kind;
    r.out_ident = id;
    r.out_port = port;
    r.out_beat = beat;
    r.out_stamp = stamp;
    r.final_item = 1'b0;
    return r;
  endfunction

  // computes the results of one item and updates the shadow table
  task automatic predict_membership(input hbmt_pkg::in_item_t it);
    hbmt_pkg::out_item_t res[$];
    hbmt_pkg::out_item_t r;
    int free_slot;
    bit found;
    free_slot = -1;
    found = 0;
    case (hbmt_pkg::func_t'(it.func))
      hbmt_pkg::FUNC_MERGE: begin
        for (int s = 0; s < ENTRIES && !found; s++) begin
          if (tbl_valid[s]) begin
            if (tbl_ident[s] == it.member_ident && tbl_port[s] == it.member_port_in) begin
              found = 1;
              if (tbl_beat[s] < it.beat_in) begin
                tbl_beat[s] = it.beat_in;
                tbl_stamp[s] = local_time;
                res.insert(res.size(), make_result(hbmt_pkg::KIND_REFRESHED, tbl_ident[s],
                                                   tbl_port[s], tbl_beat[s], tbl_stamp[s]));
              end else begin
                res.insert(res.size(), make_result(hbmt_pkg::KIND_UNCHANGED, tbl_ident[s],
                                                   tbl_port[s], tbl_beat[s], tbl_stamp[s]));
              end
            end
          end else if (free_slot < 0) begin
            free_slot = s;
          end
        end
        if (!found) begin
          if (free_slot < 0) begin
            res.insert(res.size(), make_result(hbmt_pkg::KIND_FULL, it.member_ident,
                                               it.member_port_in, it.beat_in, local_time));
          end else begin
            tbl_valid[free_slot] = 1'b1;
            tbl_ident[free_slot] = it.member_ident;
            tbl_port[free_slot] = it.member_port_in;
            tbl_beat[free_slot] = it.beat_in;
            tbl_stamp[free_slot] = local_time;
            res.insert(res.size(), make_result(hbmt_pkg::KIND_ADDED, it.member_ident,
                                               it.member_port_in, it.beat_in, local_time));
          end
        end
      end
      hbmt_pkg::FUNC_TICK: begin
        local_time = local_time + 32'd1;
        for (int s = 0; s < ENTRIES; s++)
          if (tbl_valid[s] && tbl_ident[s] == own_ident && tbl_port[s] == own_port) begin
            tbl_beat[s] = tbl_beat[s] + 32'd1;
            tbl_stamp[s] = local_time;
          end
        for (int s = 0; s < ENTRIES && res.size() < MAX_OUT; s++)
          if (tbl_valid[s] && (local_time - tbl_stamp[s]) > {16'd0, purge_limit}) begin
            res.insert(res.size(), make_result(hbmt_pkg::KIND_REMOVED, tbl_ident[s],
                                               tbl_port[s], tbl_beat[s], tbl_stamp[s]));
            tbl_valid[s] = 1'b0;
          end
      end
      hbmt_pkg::FUNC_LIST: begin
        for (int s = 0; s < ENTRIES && res.size() < MAX_OUT; s++)
          if (tbl_valid[s] && (local_time - tbl_stamp[s]) <= {16'd0, live_limit})
            res.insert(res.size(), make_result(hbmt_pkg::KIND_LIVE, tbl_ident[s],
                                               tbl_port[s], tbl_beat[s], tbl_stamp[s]));
      end
      default: ;
    endcase
    if (hbmt_pkg::func_t'(it.func) != hbmt_pkg::FUNC_NOP) begin
      if (res.size() == 0)
        res.insert(0, make_result(hbmt_pkg::KIND_NONE, '0, '0, '0, local_time));
      r = res[res.size() - 1];
      r.final_item = 1'b1;
      res[res.size() - 1] = r;
      foreach (res[i]) pending_results.insert(pending_results.size(), res[i]);
    end
  endtask

  task automatic send_item(input hbmt_pkg::func_t f, input logic [31:0] id,
                           input logic [15:0] port, input logic [31:0] beat);
    hbmt_pkg::in_item_t it;
    it.func = f;
    it.member_ident = id;
    it.member_port_in = port;
    it.beat_in = beat;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_membership(it);
    items_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // a no-op item may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      hbmt_pkg::REG_SELF_IDENT: own_ident = value;
      hbmt_pkg::REG_SELF_PORT:  own_port = value[15:0];
      hbmt_pkg::REG_FAIL_TO:    live_limit = value[15:0];
      default:                  purge_limit = value[15:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_timeouts(input logic [31:0] id, input logic [15:0] port,
                              input logic [15:0] ft, input logic [15:0] rt);
    wait_idle();
    write_reg(hbmt_pkg::REG_SELF_IDENT, id);
    write_reg(hbmt_pkg::REG_SELF_PORT, {16'd0, port});
    write_reg(hbmt_pkg::REG_FAIL_TO, {16'd0, ft});
    write_reg(hbmt_pkg::REG_REMOVE_TO, {16'd0, rt});
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d", out_item.result_kind));
      end else begin
        hbmt_pkg::out_item_t e;
        e = pending_results.pop_front();
        if (out_item.result_kind !== e.result_kind)
          report_mismatch($sformatf("kind %0d exp %0d", out_item.result_kind, e.result_kind));
        if (out_item.out_ident !== e.out_ident)
          report_mismatch($sformatf("ident %h exp %h", out_item.out_ident, e.out_ident));
        if (out_item.out_port !== e.out_port)
          report_mismatch($sformatf("port %h exp %h", out_item.out_port, e.out_port));
        if (out_item.out_beat !== e.out_beat)
          report_mismatch($sformatf("beat %h exp %h", out_item.out_beat, e.out_beat));
        if (out_item.out_stamp !== e.out_stamp)
          report_mismatch($sformatf("stamp %h exp %h", out_item.out_stamp, e.out_stamp));
        if (out_item.final_item !== e.final_item)
          report_mismatch($sformatf("final %b exp %b", out_item.final_item, e.final_item));
      end
    end
  end

  // watchdog: cycles with no traffic at all
  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy) || cfg_psel) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_TICK, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_MERGE, 32'h0, 16'h0, 32'h0);
    send_item(hbmt_pkg::FUNC_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(hbmt_pkg::FUNC_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_item(hbmt_pkg::FUNC_MERGE, 32'h0, 16'h0, 32'h5);
    send_item(hbmt_pkg::FUNC_MERGE, 32'h0, 16'h1, 32'h5);
    send_item(hbmt_pkg::FUNC_NOP, 32'h1234, 16'h1, 32'h1);
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
    // own entry ident 0 port 0 gets heartbeats on each tick
    repeat (7) send_item(hbmt_pkg::FUNC_TICK, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_MERGE, 32'h0, 16'h1, 32'h4);
  endtask

  task automatic test_wide_table();
    set_timeouts(32'hA5A5_0001, 16'h8001, 16'd3, 16'd6);
    send_item(hbmt_pkg::FUNC_MERGE, 32'hA5A5_0001, 16'h8001, 32'hFFFF_FFFE);
    // fill until full, then overflow the full table with the remaining merges
    for (int i = 0; i < ENTRIES + 2; i++)
      send_item(hbmt_pkg::FUNC_MERGE, 32'h100 + 32'(i), 16'(i), 32'(i));
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
    repeat (8) send_item(hbmt_pkg::FUNC_TICK, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
  endtask

  task automatic test_zero_timeouts();
    set_timeouts(32'hFFFF_FFFF, 16'hFFFF, 16'd0, 16'd0);
    send_item(hbmt_pkg::FUNC_MERGE, 32'hFFFF_FFFF, 16'hFFFF, 32'h10);
    send_item(hbmt_pkg::FUNC_MERGE, 32'h77, 16'h77, 32'h1);
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_TICK, '0, '0, '0);
    send_item(hbmt_pkg::FUNC_LIST, '0, '0, '0);
  endtask

  task automatic test_random(input int count, input int pool);
    logic [31:0] id;
    logic [15:0] port;
    int pick;
    for (int i = 0; i < count; i++) begin
      idle_pct = (i % 150 < 40) ? 0 : 18;
      pick = $urandom_range(99);
      id = 32'hC000_0000 + $urandom_range(pool - 1);
      port = 16'($urandom_range(3));
      if ($urandom_range(9) == 0) begin
        id = $urandom;
        port = 16'($urandom);
      end
      if (pick < 55)      send_item(hbmt_pkg::FUNC_MERGE, id, port,
                                    $urandom_range(1) ? $urandom : $urandom_range(40));
      else if (pick < 80) send_item(hbmt_pkg::FUNC_TICK, $urandom, 16'($urandom), $urandom);
      else if (pick < 97) send_item(hbmt_pkg::FUNC_LIST, $urandom, 16'($urandom), $urandom);
      else                send_item(hbmt_pkg::FUNC_NOP, $urandom, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    local_time = '0;
    own_ident = '0;
    own_port = '0;
    live_limit = 16'd5;
    purge_limit = 16'd20;
    mismatch_count = 0;
    items_sent = 0;
    results_seen = 0;
    idle_pct = 18;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_wide_table();
    test_zero_timeouts();
    set_timeouts(32'hC000_0002, 16'h1, 16'd4, 16'd10);
    test_random(150, 40);
    set_timeouts(32'hC000_0000, 16'h0, 16'hFFFF, 16'hFFFF);
    test_random(150, 48);
    set_timeouts($urandom, 16'($urandom), 16'd2, 16'd3);
    test_random(100, 20);
    wait_idle();

    $display("run covered %0d items, %0d results: merge/add/refresh/full, tick", items_sent,
             results_seen);
    $display("removal, live lists and five register settings incl. zero and max timeouts");
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ heartbeat_membership_table_unit.f @@
rtl/hbmt_pkg.sv
rtl/hbmt_front.sv
rtl/hbmt_back.sv
rtl/hbmt_regs.sv
rtl/heartbeat_membership_table_unit.sv
bench/tb_heartbeat_membership_table_unit.sv
